[design/assert_macros.svh]
// Assertion macros shared by the RTL of the circular subarray block.
// Holds nothing but macro definitions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cond holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/mcss_pkg.sv]
// Package of the circular subarray block: defaults, result width, sequencer states.
// Depends on nothing.
package mcss_pkg;

    localparam int MAX_LEN_DEF     = 1024;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int BEST_W          = 26;

    typedef enum logic [3:0] {
        S_LOAD,
        S_INIT,
        S_INIT2,
        S_FETCH,
        S_HEAD,
        S_CAND,
        S_BACK,
        S_PUSH,
        S_DONE
    } t_state;

endpackage

[design/mcss_if.sv]
// Handshake interfaces of the circular subarray block: sample input and result output.
// Uses mcss_pkg for the result width.
interface mcss_in_if #(
    parameter int SAMPLE_BITS = mcss_pkg::SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_last;

    modport source (output valid, sample, is_last, input ready);
    modport sink   (input valid, sample, is_last, output ready);
endinterface

interface mcss_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mcss_pkg::BEST_W-1:0]   best_sum;
    logic                                 length_overflow;

    modport source (output valid, best_sum, length_overflow, input ready);
    modport sink   (input valid, best_sum, length_overflow, output ready);
endinterface

[design/mcss_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
module mcss_ram #(
    parameter int W = 16,
    parameter int D = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, hold when idle
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

[design/max_circular_subarray_sum.sv]
// Maximum circular subarray sum.
// Channels: i_in carries requests {sample, is_last}; o_out carries one result
// {best_sum, length_overflow} per array, given after the is_last request.
// Loading accepts one sample per cycle; i_in.ready is high only while loading.
// Samples beyond MAX_LEN are dropped and flag length_overflow on the result.
// After is_last the block runs a pass over 2n prefix positions, re-adding the
// stored samples and keeping a monotonic queue of {index, prefix} in a RAM.
// Each position steps through fetch, head check, candidate, back compare and push
// states, skipping back compare while the queue is empty and staying in it for each
// further entry popped from the back; pops are bounded by the seed and 2n pushes,
// then the result is handed off. The queue RAM's single read port sets the pace.
// The result sits in an output register; loading of the next array starts at
// once. If the receiver stalls and the previous result is still held when a
// new pass ends, the block waits at the end of that pass until it is taken.
// Reset (i_rst_n low, synchronous) clears the sample count, the overflow flag,
// the queue pointers and the result valid; the RAMs need no clearing.
// best_sum saturates to the 26-bit signed range.
module max_circular_subarray_sum #(
    parameter int MAX_LEN     = mcss_pkg::MAX_LEN_DEF,
    parameter int SAMPLE_BITS = mcss_pkg::SAMPLE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mcss_in_if.sink    i_in,
    mcss_out_if.source o_out
);
    import mcss_pkg::*;
    `include "assert_macros.svh"

    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int SD  = (MAX_LEN > 1) ? MAX_LEN : 2;
    localparam int JW  = $clog2(2 * MAX_LEN + 1);
    localparam int PW  = SAMPLE_BITS + JW;
    localparam int QD  = MAX_LEN + 1;
    localparam int QAW = $clog2(QD);
    localparam int QCW = $clog2(QD + 1);
    localparam int EW  = JW + PW;

    t_state r_state, n_state;

    logic [CW-1:0]         r_cnt, n_cnt;
    logic                  r_ovf, n_ovf;
    logic [CW-1:0]         r_n, n_n;
    logic [SAW-1:0]        r_sidx, n_sidx;
    logic [JW-1:0]         r_j, n_j;
    logic signed [PW-1:0]  r_p, n_p;
    logic signed [PW:0]    r_best, n_best;
    logic [QAW-1:0]        r_head, n_head;
    logic [QAW-1:0]        r_tail, n_tail;
    logic [QCW-1:0]        r_qcnt, n_qcnt;
    logic                  r_ov, n_ov;
    logic signed [BEST_W-1:0] r_obest, n_obest;
    logic                  r_oovf, n_oovf;

    logic                  s_we, s_re;
    logic [SAW-1:0]        s_waddr, s_raddr;
    logic [SAMPLE_BITS-1:0] s_rdata;
    logic                  q_we, q_re;
    logic [QAW-1:0]        q_waddr, q_raddr;
    logic [EW-1:0]         q_wdata, q_rdata;

    logic [JW-1:0]         q_idx;
    logic signed [PW-1:0]  q_pre;
    logic signed [PW-1:0]  w_samp;
    logic signed [PW:0]    w_cand;
    logic [QAW-1:0]        w_back, w_back2, w_hinc;
    logic                  w_pop;
    logic signed [63:0]    w_wide;
    logic                  w_in_acc;

    assign q_idx  = q_rdata[EW-1:PW];
    assign q_pre  = q_rdata[PW-1:0];
    assign w_samp = PW'($signed(s_rdata));
    assign w_cand = {r_p[PW-1], r_p} - {q_pre[PW-1], q_pre};
    assign w_back = (r_tail == '0) ? QAW'(QD - 1) : r_tail - 1'b1;
    assign w_back2 = (w_back == '0) ? QAW'(QD - 1) : w_back - 1'b1;
    assign w_hinc = (r_head == QAW'(QD - 1)) ? '0 : r_head + 1'b1;
    assign w_pop  = (r_qcnt != '0) && (r_j > JW'(r_n)) && (q_idx < r_j - JW'(r_n));
    assign w_wide = 64'(r_best);
    assign w_in_acc = i_in.valid && i_in.ready;

    assign i_in.ready           = (r_state == S_LOAD);
    assign o_out.valid          = r_ov;
    assign o_out.best_sum       = r_obest;
    assign o_out.length_overflow = r_oovf;

    // sample and queue memories
    mcss_ram #(.W(SAMPLE_BITS), .D(SD)) u_sample_ram (
        .i_clk  (i_clk),
        .i_we   (s_we),
        .i_waddr(s_waddr),
        .i_wdata(i_in.sample),
        .i_re   (s_re),
        .i_raddr(s_raddr),
        .o_rdata(s_rdata)
    );

    mcss_ram #(.W(EW), .D(QD)) u_queue_ram (
        .i_clk  (i_clk),
        .i_we   (q_we),
        .i_waddr(q_waddr),
        .i_wdata(q_wdata),
        .i_re   (q_re),
        .i_raddr(q_raddr),
        .o_rdata(q_rdata)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_ovf  <= 1'b0;
            r_head <= '0;
            r_tail <= '0;
            r_qcnt <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_ovf  <= n_ovf;
            r_head <= n_head;
            r_tail <= n_tail;
            r_qcnt <= n_qcnt;
            r_ov   <= n_ov;
        end
        r_n     <= n_n;
        r_sidx  <= n_sidx;
        r_j     <= n_j;
        r_p     <= n_p;
        r_best  <= n_best;
        r_obest <= n_obest;
        r_oovf  <= n_oovf;
    end

    // sequencer: next state, register updates, memory requests
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ovf   = r_ovf;
        n_n     = r_n;
        n_sidx  = r_sidx;
        n_j     = r_j;
        n_p     = r_p;
        n_best  = r_best;
        n_head  = r_head;
        n_tail  = r_tail;
        n_qcnt  = r_qcnt;
        n_ov    = r_ov && !o_out.ready;
        n_obest = r_obest;
        n_oovf  = r_oovf;
        s_we    = 1'b0;
        s_waddr = r_cnt[SAW-1:0];
        s_re    = 1'b0;
        s_raddr = r_sidx;
        q_we    = 1'b0;
        q_waddr = r_tail;
        q_wdata = {r_j, r_p};
        q_re    = 1'b0;
        q_raddr = r_head;

        unique case (r_state)
            S_LOAD: begin
                // store the sample or drop it once full
                if (w_in_acc) begin
                    if (r_cnt < CW'(MAX_LEN)) begin
                        s_we  = 1'b1;
                        n_cnt = r_cnt + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in.is_last) begin
                        n_n = (r_cnt < CW'(MAX_LEN)) ? r_cnt + 1'b1 : r_cnt;
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                // seed the queue with prefix index 0, fetch the first sample
                q_we    = 1'b1;
                q_waddr = '0;
                q_wdata = '0;
                s_re    = 1'b1;
                s_raddr = '0;
                n_head  = '0;
                n_tail  = QAW'(1);
                n_qcnt  = QCW'(1);
                n_sidx  = '0;
                n_j     = JW'(1);
                n_p     = '0;
                n_state = S_INIT2;
            end
            S_INIT2: begin
                n_best  = (PW + 1)'($signed(s_rdata));
                n_state = S_FETCH;
            end
            S_FETCH: begin
                // read the next sample and the queue head
                s_re    = 1'b1;
                q_re    = 1'b1;
                q_raddr = r_head;
                n_state = S_HEAD;
            end
            S_HEAD: begin
                // advance the prefix, drop a head that left the window
                n_p    = r_p + w_samp;
                n_sidx = (CW'(r_sidx) == r_n - 1'b1) ? '0 : r_sidx + 1'b1;
                q_re   = 1'b1;
                if (w_pop) begin
                    n_head  = w_hinc;
                    n_qcnt  = r_qcnt - 1'b1;
                    q_raddr = w_hinc;
                end else begin
                    q_raddr = r_head;
                end
                n_state = S_CAND;
            end
            S_CAND: begin
                // score against the window minimum, then look at the back
                if (r_qcnt != '0) begin
                    if (w_cand > r_best) begin
                        n_best = w_cand;
                    end
                    q_re    = 1'b1;
                    q_raddr = w_back;
                    n_state = S_BACK;
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_BACK: begin
                // pop back entries whose prefix is not below the new one
                if (r_qcnt != '0 && r_p <= q_pre) begin
                    n_tail = w_back;
                    n_qcnt = r_qcnt - 1'b1;
                    if (r_qcnt > QCW'(1)) begin
                        q_re    = 1'b1;
                        q_raddr = w_back2;
                    end else begin
                        n_state = S_PUSH;
                    end
                end else begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                // append the new prefix, step to the next position
                if (r_qcnt < QCW'(QD)) begin
                    q_we   = 1'b1;
                    n_tail = (r_tail == QAW'(QD - 1)) ? '0 : r_tail + 1'b1;
                    n_qcnt = r_qcnt + 1'b1;
                end
                if ({1'b0, r_j} == (JW + 1)'({r_n, 1'b0})) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_FETCH;
                end
            end
            S_DONE: begin
                // hand off the saturated result once the output register is free
                if (!r_ov || o_out.ready) begin
                    n_ov  = 1'b1;
                    n_oovf = r_ovf;
                    if (w_wide > 64'sd33554431) begin
                        n_obest = BEST_W'(64'sd33554431);
                    end else if (w_wide < -64'sd33554432) begin
                        n_obest = BEST_W'(-64'sd33554432);
                    end else begin
                        n_obest = BEST_W'(w_wide);
                    end
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    `ASSERT_ALWAYS(a_qcnt_bound, i_clk, i_rst_n, r_qcnt <= QCW'(QD), "queue count over depth")
    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(MAX_LEN), "sample count over limit")
    `ASSERT_NEXT(a_last_starts, i_clk, i_rst_n, w_in_acc && i_in.is_last,
        r_state == S_INIT && r_n != '0, "last request did not start a pass")
endmodule
